>>> rtl/irs_pkg.sv
// Package: route record types, netmask and compare helpers for the route summariser.
package irs_pkg;

	localparam int DefMaxRoutes = 64;
	localparam int AddrW = 32;
	localparam int PlenW = 6;
	localparam int MetW = 16;

	typedef struct packed {
		logic [AddrW-1:0] route_address;
		logic [PlenW-1:0] prefix_length;
		logic [MetW-1:0]  route_metric;
		logic             last_route;
	} route_in_t;

	typedef struct packed {
		logic [AddrW-1:0] out_address;
		logic [PlenW-1:0] out_prefix;
		logic [MetW-1:0]  out_metric;
		logic             list_changed;
		logic             capacity_overflow;
		logic             end_of_list;
	} route_out_t;

	typedef struct packed {
		logic [AddrW-1:0] addr;
		logic [PlenW-1:0] plen;
		logic [MetW-1:0]  met;
	} route_t;

	// Netmask for a prefix length; lengths above 32 count as 32.
	function automatic logic [AddrW-1:0] plen_mask(input logic [PlenW-1:0] p);
		logic [AddrW-1:0] m;
		m = '0;
		if (p >= PlenW'(AddrW)) begin
			m = '1;
		end else if (p != '0) begin
			m = ~({AddrW{1'b1}} >> p[4:0]);
		end
		return m;
	endfunction

	// Order used by the merge pass: metric asc, length desc, network asc.
	function automatic logic main_before(input route_t x, input route_t y);
		logic r;
		if (x.met != y.met) begin
			r = x.met < y.met;
		end else if (x.plen != y.plen) begin
			r = x.plen > y.plen;
		end else begin
			r = x.addr < y.addr;
		end
		return r;
	endfunction

	// Order used by the overlap pass: network, length, metric, all asc.
	function automatic logic ovl_before(input route_t x, input route_t y);
		logic r;
		if (x.addr != y.addr) begin
			r = x.addr < y.addr;
		end else if (x.plen != y.plen) begin
			r = x.plen < y.plen;
		end else begin
			r = x.met < y.met;
		end
		return r;
	endfunction

endpackage

>>> rtl/irs_core.sv
// Module: table memory, sort and pass sequencer of the route summariser.
module irs_core #(
	parameter int MaxRoutes = irs_pkg::DefMaxRoutes
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  irs_pkg::route_in_t item,
	output logic               busy,
	output logic               strobe,
	output irs_pkg::route_out_t result
);
	import irs_pkg::*;

	localparam int IdxW = (MaxRoutes > 1) ? $clog2(MaxRoutes) : 1;
	localparam int CntW = $clog2(MaxRoutes + 1);

	localparam logic [3:0] StIdle  = 4'd0;
	localparam logic [3:0] StSortI = 4'd1;  // fetch entry i as key
	localparam logic [3:0] StSortW = 4'd2;  // key read settles
	localparam logic [3:0] StSortJ = 4'd3;  // read entry j-1
	localparam logic [3:0] StSortC = 4'd4;  // compare and shift
	localparam logic [3:0] StPassR = 4'd5;  // read entry i
	localparam logic [3:0] StPassC = 4'd6;  // merge / drop decision
	localparam logic [3:0] StPassK = 4'd7;  // reload kept entry
	localparam logic [3:0] StOutR  = 4'd8;
	localparam logic [3:0] StOutE  = 4'd9;
	localparam logic [3:0] StPassS = 4'd10; // pass start, read entry 0

	localparam logic [1:0] PhMain = 2'd0;
	localparam logic [1:0] PhOvl1 = 2'd1;
	localparam logic [1:0] PhOvl2 = 2'd2;

	route_t mem [MaxRoutes];
	route_t rd_q;
	logic [IdxW-1:0] ra;
	logic            we;
	logic [IdxW-1:0] wa;
	route_t          wd;

	logic [3:0]      st_q;
	logic [1:0]      ph_q;
	logic [CntW-1:0] cnt_q, i_q, j_q, k_q;
	logic            ovf_q, merged_q, drop_q;
	route_t          key_q, kept_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	logic   sort_lt;
	route_t ld;
	logic [AddrW-1:0] nextnet, bcast;
	logic   join_ok, drop_ok;

	always_comb begin
		ld.plen = (item.prefix_length > PlenW'(AddrW)) ? PlenW'(AddrW) : item.prefix_length;
		ld.addr = item.route_address & plen_mask(ld.plen);
		ld.met  = item.route_metric;
		sort_lt = (ph_q == PhMain) ? main_before(key_q, rd_q) : ovl_before(key_q, rd_q);
		bcast   = kept_q.addr | ~plen_mask(kept_q.plen);
		nextnet = bcast + 1'b1;
		join_ok = kept_q.plen == rd_q.plen && kept_q.met == rd_q.met && bcast != '1 &&
			nextnet == rd_q.addr && kept_q.plen != '0 &&
			(kept_q.addr & plen_mask(kept_q.plen - 1'b1)) == kept_q.addr;
		drop_ok = (rd_q.addr & plen_mask(kept_q.plen)) == kept_q.addr &&
			rd_q.met >= kept_q.met;
	end

	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = key_q;
		ra = '0;
		unique case (st_q)
			StIdle: begin
				we = start && cnt_q < CntW'(MaxRoutes);
				wa = cnt_q[IdxW-1:0];
				wd = ld;
			end
			StSortI: ra = i_q[IdxW-1:0];
			StSortJ: ra = IdxW'(j_q - 1'b1);
			StSortC: begin
				if (j_q != '0 && sort_lt) begin
					we = 1'b1;
					wa = j_q[IdxW-1:0];
					wd = rd_q;
				end else begin
					we = 1'b1;
					wa = j_q[IdxW-1:0];
					wd = key_q;
				end
				ra = IdxW'(j_q - 2'd2);
			end
			StPassS: ra = '0;
			StPassR: ra = i_q[IdxW-1:0];
			StPassC: begin
				if (ph_q == PhMain ? !join_ok : !drop_ok) begin
					we = 1'b1;
					wa = k_q[IdxW-1:0];
					wd = rd_q;
				end else if (ph_q == PhMain) begin
					we = 1'b1;
					wa = IdxW'(k_q - 1'b1);
					wd = kept_q;
					wd.plen = kept_q.plen - 1'b1;
				end
			end
			StOutR: ra = i_q[IdxW-1:0];
			default: ra = i_q[IdxW-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StIdle;
			ph_q <= PhMain;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			merged_q <= 1'b0;
			drop_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			key_q <= '0;
			kept_q <= '0;
			strobe <= 1'b0;
			result <= '0;
		end else begin
			strobe <= 1'b0;
			unique case (st_q)
				StIdle: begin
					if (start) begin
						if (cnt_q < CntW'(MaxRoutes)) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (item.last_route) begin
							ph_q <= PhMain;
							merged_q <= 1'b0;
							drop_q <= 1'b0;
							i_q <= CntW'(1);
							st_q <= StSortI;
						end
					end
				end
				StSortI: begin
					if (i_q >= cnt_q) begin
						st_q <= StPassS;
					end else begin
						j_q <= i_q;
						st_q <= StSortW;
					end
				end
				StSortW: begin
					key_q <= rd_q;
					st_q <= StSortJ;
				end
				StSortJ: st_q <= StSortC;
				StSortC: begin
					if (j_q != '0 && sort_lt) begin
						j_q <= j_q - 1'b1;
						if (j_q == CntW'(1)) begin
							st_q <= StSortC;
						end
						// next read (j-2) was issued this cycle
					end else begin
						i_q <= i_q + 1'b1;
						st_q <= StSortI;
					end
				end
				StPassS: begin
					i_q <= CntW'(1);
					k_q <= CntW'(1);
					st_q <= StPassK;
				end
				StPassK: begin
					kept_q <= rd_q;
					st_q <= StPassR;
				end
				StPassR: begin
					if (i_q >= cnt_q) begin
						cnt_q <= k_q;
						if (ph_q == PhMain) begin
							ph_q <= merged_q ? PhOvl1 : PhOvl2;
							i_q <= CntW'(1);
							st_q <= StSortI;
						end else if (ph_q == PhOvl1) begin
							ph_q <= PhOvl2;
							drop_q <= 1'b0;
							i_q <= CntW'(1);
							st_q <= StSortI;
						end else begin
							i_q <= '0;
							st_q <= StOutR;
						end
					end else begin
						st_q <= StPassC;
					end
				end
				StPassC: begin
					i_q <= i_q + 1'b1;
					if (ph_q == PhMain ? !join_ok : !drop_ok) begin
						kept_q <= rd_q;
						k_q <= k_q + 1'b1;
					end else if (ph_q == PhMain) begin
						kept_q.plen <= kept_q.plen - 1'b1;
						merged_q <= 1'b1;
					end else begin
						drop_q <= 1'b1;
					end
					st_q <= StPassR;
				end
				StOutR: st_q <= StOutE;
				StOutE: begin
					strobe <= 1'b1;
					result.out_address <= rd_q.addr;
					result.out_prefix <= rd_q.plen;
					result.out_metric <= rd_q.met;
					result.list_changed <= merged_q | drop_q;
					result.capacity_overflow <= ovf_q;
					result.end_of_list <= (i_q + 1'b1 == cnt_q);
					i_q <= i_q + 1'b1;
					if (i_q + 1'b1 == cnt_q) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
						st_q <= StIdle;
					end else begin
						st_q <= StOutR;
					end
				end
				default: st_q <= StIdle;
			endcase
		end
	end

	assign busy = st_q != StIdle;

endmodule

>>> rtl/ipv4_route_summarizer.sv
// Top level: IPv4 route summariser wrapping the table sequencer.
// Operation: loading accepts one item per cycle while idle; after the last item the
// table is insertion-sorted and walked in a pass, up to three sorts and passes, then
// emitted one item at a time while busy; results cannot be held off.
// Reset (arst_n low) empties the table count and clears the overflow flag.
module ipv4_route_summarizer #(
	parameter int MaxRoutes = irs_pkg::DefMaxRoutes
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  irs_pkg::route_in_t  item,
	output logic                busy,
	output logic                strobe,
	output irs_pkg::route_out_t result
);
	import irs_pkg::*;

	// Hold the whole list in one memory; sort and walk it under a sequencer.
	irs_core #(.MaxRoutes(MaxRoutes)) u_core (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item),
		.busy(busy), .strobe(strobe), .result(result)
	);

endmodule

>>> rtl/irs_checker.sv
// Checker: port-level properties of the route summariser, bound to the top level.
module irs_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                strobe,
	input irs_pkg::route_out_t result
);
	import irs_pkg::*;

	a_idle_on_eol: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && result.end_of_list)
		else $error("busy dropped without final result");
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.end_of_list |-> busy)
		else $error("result outside busy window");
	a_eol_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.end_of_list |-> !busy)
		else $error("busy after end of list");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("back-to-back results");
endmodule

bind ipv4_route_summarizer irs_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.strobe(strobe), .result(result)
);

>>> sim/ipv4_route_summarizer_test.sv
// Testbench for the IPv4 route summariser: route lists in, summarised routes checked.
`timescale 1ns / 1ps

module ipv4_route_summarizer_test;
	import irs_pkg::*;

	localparam int Depth = DefMaxRoutes;

	logic       clk;
	logic       arst_n;
	logic       start;
	route_in_t  item;
	logic       busy;
	logic       strobe;
	route_out_t result;

	ipv4_route_summarizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.strobe(strobe),
		.result(result)
	);

	// Predictor copy of the route table
	route_t     tbl[Depth];
	int         tbl_count;
	logic       lost_route;
	route_out_t summary_queue[$];
	int         failures;
	bit         sender_gaps;

	always #2 clk = ~clk;

	function automatic logic [AddrW-1:0] netmask(input int p);
		if (p <= 0) return '0;
		if (p >= 32) return '1;
		return ~(32'hFFFF_FFFF >> p);
	endfunction

	// Ordering for the merge pass: metric up, length down, network up.
	function automatic bit merge_order(input route_t x, input route_t y);
		if (x.met != y.met) return x.met < y.met;
		if (x.plen != y.plen) return x.plen > y.plen;
		return x.addr < y.addr;
	endfunction

	// Ordering for the overlap pass: network, length, metric, all up.
	function automatic bit cover_order(input route_t x, input route_t y);
		if (x.addr != y.addr) return x.addr < y.addr;
		if (x.plen != y.plen) return x.plen < y.plen;
		return x.met < y.met;
	endfunction

	// Stable insertion sort of the live part of the table.
	task automatic sort_routes(input bit by_merge);
		route_t cur;
		int j;
		bit ahead;
		for (int i = 1; i < tbl_count; i++) begin
			cur = tbl[i];
			j = i;
			while (j > 0) begin
				ahead = by_merge ? merge_order(cur, tbl[j-1]) : cover_order(cur, tbl[j-1]);
				if (!ahead) break;
				tbl[j] = tbl[j-1];
				j--;
			end
			tbl[j] = cur;
		end
	endtask

	task automatic merge_siblings(output bit merged);
		int kept;
		logic [32:0] next_net;
		route_t lk;
		merged = 0;
		if (tbl_count == 0) return;
		sort_routes(1);
		kept = 1;
		for (int i = 1; i < tbl_count; i++) begin
			lk = tbl[kept-1];
			next_net = {1'b0, lk.addr | ~netmask(lk.plen)} + 33'd1;
			if (lk.plen == tbl[i].plen && lk.met == tbl[i].met && !next_net[32] &&
			    next_net[31:0] == tbl[i].addr && lk.plen != 0 &&
			    (lk.addr & netmask(int'(lk.plen) - 1)) == lk.addr) begin
				tbl[kept-1].plen = lk.plen - 1'b1;
				merged = 1;
			end else begin
				tbl[kept] = tbl[i];
				kept++;
			end
		end
		tbl_count = kept;
	endtask

	task automatic drop_covered(output bit dropped);
		int kept;
		route_t lk;
		dropped = 0;
		if (tbl_count == 0) return;
		sort_routes(0);
		kept = 1;
		for (int i = 1; i < tbl_count; i++) begin
			lk = tbl[kept-1];
			if ((tbl[i].addr & netmask(lk.plen)) == lk.addr && tbl[i].met >= lk.met) begin
				dropped = 1;
			end else begin
				tbl[kept] = tbl[i];
				kept++;
			end
		end
		tbl_count = kept;
	endtask

	// Load one route into the predictor; on the last route, summarise and queue the results.
	task automatic predict_route(input route_in_t r);
		int plen;
		bit changed, dropped;
		route_out_t o;
		plen = (r.prefix_length > 32) ? 32 : int'(r.prefix_length);
		if (tbl_count < Depth) begin
			tbl[tbl_count].addr = r.route_address & netmask(plen);
			tbl[tbl_count].plen = PlenW'(plen);
			tbl[tbl_count].met = r.route_metric;
			tbl_count++;
		end else begin
			lost_route = 1'b1;
		end
		if (!r.last_route) return;
		merge_siblings(changed);
		if (changed) drop_covered(dropped);
		drop_covered(dropped);
		if (dropped) changed = 1;
		for (int i = 0; i < tbl_count; i++) begin
			o.out_address = tbl[i].addr;
			o.out_prefix = tbl[i].plen;
			o.out_metric = tbl[i].met;
			o.list_changed = changed;
			o.capacity_overflow = lost_route;
			o.end_of_list = (i == tbl_count - 1);
			summary_queue.push_back(o);
		end
		tbl_count = 0;
		lost_route = 1'b0;
	endtask

	// Drive one item, wait for acceptance, then predict it.
	task automatic send_route(input logic [31:0] a, input int p, input int m, input bit last);
		route_in_t r;
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		r.route_address = a;
		r.prefix_length = PlenW'(p);
		r.route_metric = MetW'(m);
		r.last_route = last;
		item <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		predict_route(r);
		@(negedge clk);
	endtask

	// Hold until every expected result has arrived.
	task automatic drain;
		start <= 1'b0;
		@(negedge clk);
		while (summary_queue.size() != 0) @(negedge clk);
	endtask

	// Check each result against the oldest expectation.
	always @(posedge clk) begin
		route_out_t want;
		if (arst_n && strobe) begin
			if (summary_queue.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				failures++;
			end else begin
				want = summary_queue.pop_front();
				if (result.out_address !== want.out_address ||
				    result.out_prefix !== want.out_prefix ||
				    result.out_metric !== want.out_metric ||
				    result.list_changed !== want.list_changed ||
				    result.capacity_overflow !== want.capacity_overflow ||
				    result.end_of_list !== want.end_of_list) begin
					$display("%0t: mismatch expected %h actual %h", $time, want, result);
					failures++;
				end
			end
		end
	end

	// Field extremes, prefix lengths above 32 and a zero-length route.
	task automatic test_extremes;
		send_route(32'hFFFF_FFFF, 63, 16'hFFFF, 0);
		send_route(32'hFFFF_FFFF, 32, 0, 0);
		send_route(32'h1234_5678, 0, 5, 0);
		send_route(32'h0000_0000, 33, 5, 0);
		send_route(32'hAAAA_5555, 42, 16'h8000, 1);
		drain();
	endtask

	// Sibling halves merging, zero-length never merging, duplicates, coverage.
	task automatic test_merging;
		send_route(32'h0A00_0000, 24, 10, 0);
		send_route(32'h0A00_0100, 24, 10, 0);
		send_route(32'h0A00_0200, 24, 10, 0);
		send_route(32'h0A00_0300, 24, 10, 0);
		send_route(32'h0A00_0500, 24, 10, 0); // odd half, no merge with upper
		send_route(32'h0A00_0600, 24, 10, 0);
		send_route(32'hC0A8_0100, 24, 3, 0);
		send_route(32'hC0A8_0100, 24, 3, 0); // duplicate
		send_route(32'hC0A8_0180, 25, 7, 0); // covered, worse metric
		send_route(32'hC0A8_01C0, 26, 1, 0); // covered, better metric: kept
		send_route(32'hFFFF_FFFE, 32, 4, 0);
		send_route(32'hFFFF_FFFF, 32, 4, 0);
		send_route(32'h0, 0, 9, 0);
		send_route(32'h0, 0, 9, 1);
		drain();
	endtask

	// Fill past capacity, ending with a dropped last route; then a one-route list.
	task automatic test_overflow;
		for (int i = 0; i < Depth + 3; i++)
			send_route($urandom, $urandom_range(0, 40), $urandom_range(0, 3), i == Depth + 2);
		drain();
		send_route($urandom, $urandom_range(0, 32), $urandom, 1);
		drain();
	endtask

	// Random lists: mostly structured sibling blocks, some noise.
	task automatic test_random_lists(input int n_items);
		int sent, len, p, m;
		logic [31:0] base;
		sent = 0;
		while (sent < n_items) begin
			len = $urandom_range(1, 12);
			base = $urandom;
			m = $urandom_range(0, 2);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 3) != 0) begin
					p = $urandom_range(20, 30);
					send_route(base + (i << (32 - p)), p, m, i == len - 1);
				end else begin
					send_route($urandom, $urandom_range(0, 63), $urandom, i == len - 1);
				end
			end
			sent += len;
		end
		drain();
	endtask

	initial begin
		clk = 0;
		arst_n = 0;
		start = 0;
		item = '0;
		failures = 0;
		tbl_count = 0;
		lost_route = 1'b0;
		sender_gaps = 1;
		repeat (9) @(negedge clk);
		arst_n = 1;
		test_extremes();
		test_merging();
		test_overflow();
		test_random_lists(8);
		sender_gaps = 0;
		test_random_lists(4);
		repeat (200) @(negedge clk);
		if (failures == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	// Limit: allow for worst-case sorts of a full table several times over.
	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
